@@ hdl/rafe_pkg.sv @@
// Shared types, constants and helpers for the rotational anisotropy field/energy core.
// Stream layout, coefficient select codes and saturation functions live here.
// No dependencies.
package rafe_pkg;

	localparam int NUM_MATERIALS_DEF = 16;

	localparam int MAT_W   = 4;
	localparam int SEL_W   = 3;
	localparam int COEF_W  = 24;
	localparam int SPIN_W  = 16;
	localparam int FIELD_W = 32;

	// Pipeline depth from input beat to output register.
	localparam int NUM_STG = 11;

	// Item kinds.
	localparam logic MODE_ATOM = 1'b0;
	localparam logic MODE_COEF = 1'b1;

	// Coefficient select codes.
	localparam logic [SEL_W-1:0] SEL_X_AXIS   = 3'd0;
	localparam logic [SEL_W-1:0] SEL_Y_AXIS   = 3'd3;
	localparam logic [SEL_W-1:0] SEL_STRENGTH = 3'd6;

	// Input beat layout.
	localparam int S_TDATA_W = 176;
	localparam int S_TUSER_W = 4;
	localparam int OFS_MAT   = 0;
	localparam int OFS_COEF  = 4;
	localparam int OFS_SPIN  = 28;
	localparam int OFS_FIELD = 76;
	localparam int TU_MODE   = 0;
	localparam int TU_SEL    = 1;

	// Output beat layout.
	localparam int M_TDATA_W = 128;

	typedef logic signed [SPIN_W-1:0]  axis_t;
	typedef logic signed [COEF_W-1:0]  str_t;
	typedef logic signed [FIELD_W-1:0] field_t;

	typedef struct packed {
		axis_t [2:0] f;
		axis_t [2:0] g;
		str_t        k;
	} coef_t;

	typedef struct packed {
		field_t [2:0] fin;
		logic         last;
		logic         en;
	} side_t;

	typedef struct packed {
		field_t [2:0] fout;
		field_t       energy;
		logic         last;
	} result_t;

	function automatic axis_t sat16(input logic signed [23:0] v);
		if (v > 24'sd32767) begin
			return 16'sh7fff;
		end else if (v < -24'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic field_t sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

@@ hdl/rafe_coef_mem.sv @@
// Per-material coefficient memories: two local axes and the strength.
// Written one coefficient per beat, read one whole entry with a registered port.
// Depends on rafe_pkg.
module rafe_coef_mem #(
	parameter int NUM_MATERIALS = rafe_pkg::NUM_MATERIALS_DEF
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [rafe_pkg::MAT_W-1:0] wr_mat,
	input  logic [rafe_pkg::SEL_W-1:0] wr_sel,
	input  rafe_pkg::str_t             wr_val,
	input  logic                       rd_en,
	input  logic [rafe_pkg::MAT_W-1:0] rd_mat,
	output rafe_pkg::coef_t            rd_data
);
	import rafe_pkg::*;

	localparam int AW    = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;
	localparam int EXT_W = (AW > MAT_W) ? AW : MAT_W;

	axis_t x_mem [3][NUM_MATERIALS];
	axis_t y_mem [3][NUM_MATERIALS];
	str_t  k_mem [NUM_MATERIALS];

	logic [EXT_W-1:0] wr_ext, rd_ext;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic             wr_ok, rd_ok;
	logic [1:0]       y_idx;
	axis_t            wr_axis;
	coef_t            rd_q;
	logic             rd_ok_q;

	assign wr_ext  = EXT_W'(wr_mat);
	assign rd_ext  = EXT_W'(rd_mat);
	assign wr_addr = wr_ext[AW-1:0];
	assign rd_addr = rd_ext[AW-1:0];
	assign wr_ok   = wr_en && (32'(wr_mat) < 32'(NUM_MATERIALS));
	assign rd_ok   = 32'(rd_mat) < 32'(NUM_MATERIALS);
	assign y_idx   = 2'(wr_sel - SEL_Y_AXIS);
	assign wr_axis = sat16(wr_val);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			if (wr_sel < SEL_Y_AXIS) begin
				x_mem[wr_sel[1:0]][wr_addr] <= wr_axis;
			end else if (wr_sel < SEL_STRENGTH) begin
				y_mem[y_idx][wr_addr] <= wr_axis;
			end else if (wr_sel == SEL_STRENGTH) begin
				k_mem[wr_addr] <= wr_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int i = 0; i < 3; i++) begin
				rd_q.f[i] <= x_mem[i][rd_addr];
				rd_q.g[i] <= y_mem[i][rd_addr];
			end
			rd_q.k  <= k_mem[rd_addr];
			rd_ok_q <= rd_ok;
		end
	end

	// A material beyond the table sees an all-zero entry.
	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

@@ hdl/rafe_datapath.sv @@
// Arithmetic pipeline, stages two through eleven: projection, cubic terms,
// strength scaling, field update and energy. Depends on rafe_pkg.
module rafe_datapath (
	input  logic                            clk,
	input  logic [rafe_pkg::NUM_STG:2]      adv,
	input  rafe_pkg::axis_t [2:0]           spin_s1,
	input  rafe_pkg::coef_t                 coef_s1,
	input  rafe_pkg::side_t                 side_s1,
	output rafe_pkg::result_t               res
);
	import rafe_pkg::*;

	logic signed [31:0] pf_s2 [3];
	logic signed [31:0] pg_s2 [3];
	coef_t              coef_s2, coef_s3, coef_s4, coef_s5, coef_s6, coef_s7, coef_s8;
	side_t              side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	side_t              side_s9, side_s10;

	axis_t              sx_s3, sy_s3, sx_s4, sy_s4;
	logic signed [31:0] sx2_s4, sy2_s4;
	logic signed [49:0] cxr_s5, cyr_s5;
	logic signed [63:0] sx4_s5, sxy_s5, sy4_s5;
	logic signed [35:0] cx_s6, cy_s6;
	logic signed [37:0] p_s6;
	logic signed [59:0] kcx_s7, kcy_s7;
	logic signed [61:0] kp_s7;
	logic signed [33:0] ax_s8, ay_s8;
	field_t             energy_s8, energy_s9, energy_s10;
	logic signed [49:0] axf_s9 [3];
	logic signed [49:0] ayg_s9 [3];
	logic signed [36:0] add_s10 [3];
	result_t            res_s11;

	logic signed [33:0] sum_x, sum_y;
	logic signed [33:0] tx, ty;
	logic signed [49:0] rcx, rcy;
	logic signed [65:0] psum;
	logic signed [59:0] rax, ray;
	logic signed [62:0] negkp;

	// Stage 2: spin times each axis component.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				pf_s2[i] <= $signed(spin_s1[i]) * $signed(coef_s1.f[i]);
				pg_s2[i] <= $signed(spin_s1[i]) * $signed(coef_s1.g[i]);
			end
			coef_s2 <= coef_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: sum, round and saturate the projections.
	assign sum_x = 34'(pf_s2[0]) + 34'(pf_s2[1]) + 34'(pf_s2[2]) + 34'sd8192;
	assign sum_y = 34'(pg_s2[0]) + 34'(pg_s2[1]) + 34'(pg_s2[2]) + 34'sd8192;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sx_s3   <= sat16(24'($signed(sum_x[33:14])));
			sy_s3   <= sat16(24'($signed(sum_y[33:14])));
			coef_s3 <= coef_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: squares.
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			sx2_s4  <= sx_s3 * sx_s3;
			sy2_s4  <= sy_s3 * sy_s3;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			coef_s4 <= coef_s3;
			side_s4 <= side_s3;
		end
	end

	// Stage 5: cubic field terms and the fourth-power energy terms.
	assign tx = 34'(sx2_s4) - 34'sd3 * 34'(sy2_s4);
	assign ty = 34'(sy2_s4) - 34'sd3 * 34'(sx2_s4);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			cxr_s5  <= sx_s4 * tx;
			cyr_s5  <= sy_s4 * ty;
			sx4_s5  <= sx2_s4 * sx2_s4;
			sxy_s5  <= sx2_s4 * sy2_s4;
			sy4_s5  <= sy2_s4 * sy2_s4;
			coef_s5 <= coef_s4;
			side_s5 <= side_s4;
		end
	end

	// Stage 6: round to Q.28 by dropping 14 and 28 bits with half-up rounding.
	assign rcx  = cxr_s5 + 50'sd8192;
	assign rcy  = cyr_s5 + 50'sd8192;
	assign psum = 66'(sx4_s5) - 66'sd6 * 66'(sxy_s5) + 66'(sy4_s5) + 66'sd134217728;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			cx_s6   <= rcx[49:14];
			cy_s6   <= rcy[49:14];
			p_s6    <= psum[65:28];
			coef_s6 <= coef_s5;
			side_s6 <= side_s5;
		end
	end

	// Stage 7: scale by the strength.
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			kcx_s7  <= $signed(coef_s6.k) * cx_s6;
			kcy_s7  <= $signed(coef_s6.k) * cy_s6;
			kp_s7   <= $signed(coef_s6.k) * p_s6;
			coef_s7 <= coef_s6;
			side_s7 <= side_s6;
		end
	end

	// Stage 8: the factor four folds into a shift of 26 instead of 28.
	assign rax   = kcx_s7 + 60'sd33554432;
	assign ray   = kcy_s7 + 60'sd33554432;
	assign negkp = -63'(kp_s7) + 63'sd134217728;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			ax_s8     <= rax[59:26];
			ay_s8     <= ray[59:26];
			energy_s8 <= sat32(40'($signed(negkp[62:28])));
			coef_s8   <= coef_s7;
			side_s8   <= side_s7;
		end
	end

	// Stage 9: project the local field back onto the lab axes.
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			for (int i = 0; i < 3; i++) begin
				axf_s9[i] <= ax_s8 * $signed(coef_s8.f[i]);
				ayg_s9[i] <= ay_s8 * $signed(coef_s8.g[i]);
			end
			energy_s9 <= energy_s8;
			side_s9   <= side_s8;
		end
	end

	// Stage 10: combine and round to Q16.16.
	always_ff @(posedge clk) begin
		logic signed [50:0] t;
		if (adv[10]) begin
			for (int i = 0; i < 3; i++) begin
				t          = 51'(axf_s9[i]) + 51'(ayg_s9[i]) + 51'sd8192;
				add_s10[i] <= t[50:14];
			end
			energy_s10 <= energy_s9;
			side_s10   <= side_s9;
		end
	end

	// Stage 11: accumulate onto the incoming field, or pass it when disabled.
	always_ff @(posedge clk) begin
		if (adv[11]) begin
			for (int i = 0; i < 3; i++) begin
				res_s11.fout[i] <= side_s10.en
					? sat32(40'(side_s10.fin[i]) + 40'(add_s10[i]))
					: side_s10.fin[i];
			end
			res_s11.energy <= side_s10.en ? energy_s10 : '0;
			res_s11.last   <= side_s10.last;
		end
	end

	assign res = res_s11;

endmodule

@@ hdl/rotational_anisotropy_field_energy_core.sv @@
// Top level of the rotational anisotropy field/energy core.
// Depends on rafe_pkg, rafe_coef_mem and rafe_datapath.
//
// Input beats on s_axis carry either an atom (tuser mode 0) or one material
// coefficient (tuser mode 1). A coefficient beat writes the material table
// and returns nothing. An atom beat returns one beat on m_axis with the
// updated field, the atom's energy and tlast copied from the input.
// The enable register is written through cfg_wr_en/cfg_wr_data; write it only
// while idle, the core itself does not enforce that. With enable low the field
// passes unchanged and the energy is zero. Throughput is one beat per cycle
// while m_axis_tready keeps the pipeline moving. The table read fills the
// first of eleven register stages and the multiply chain fills the other ten.
// Each stage holds its own valid bit, so the core keeps taking beats into
// empty stages while a result waits on a stalled m_axis_tready; it stops
// only when every stage is full.
// Reset clears all stage valids and the enable register. The material table
// is not cleared: an entry must be written before an atom uses it.
module rotational_anisotropy_field_energy_core #(
	parameter int NUM_MATERIALS = rafe_pkg::NUM_MATERIALS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// material, coef_value, spin_x, spin_y, spin_z, field_in_x, field_in_y, field_in_z
	input  logic [rafe_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// mode, coef_select
	input  logic [rafe_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// field_out_x, field_out_y, field_out_z, energy
	output logic [rafe_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tlast
);
	import rafe_pkg::*;

	logic               enable_q;
	logic [NUM_STG:1]   v_q;
	logic [NUM_STG:1]   adv;
	logic               s_acc;
	logic               in_mode;
	logic [SEL_W-1:0]   in_sel;
	logic [MAT_W-1:0]   in_mat;
	str_t               in_coef;
	axis_t [2:0]        in_spin;
	field_t [2:0]       in_field;
	axis_t [2:0]        spin_s1;
	side_t              side_s1;
	coef_t              coef_s1;
	result_t            res;

	assign in_mode = s_axis_tuser[TU_MODE];
	assign in_sel  = s_axis_tuser[TU_SEL +: SEL_W];
	assign in_mat  = s_axis_tdata[OFS_MAT +: MAT_W];
	assign in_coef = s_axis_tdata[OFS_COEF +: COEF_W];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_spin[i]  = s_axis_tdata[OFS_SPIN + i*SPIN_W +: SPIN_W];
			in_field[i] = s_axis_tdata[OFS_FIELD + i*FIELD_W +: FIELD_W];
		end
	end

	// A stage may load when it is empty or the stage after it moves on.
	always_comb begin
		adv[NUM_STG] = !v_q[NUM_STG] || m_axis_tready;
		for (int i = NUM_STG - 1; i >= 1; i--) begin
			adv[i] = !v_q[i] || adv[i+1];
		end
	end

	assign s_axis_tready = adv[1];
	assign s_acc         = s_axis_tvalid && adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[1]) begin
				v_q[1] <= s_acc && (in_mode == MODE_ATOM);
			end
			for (int i = 2; i <= NUM_STG; i++) begin
				if (adv[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			spin_s1      <= in_spin;
			side_s1.fin  <= in_field;
			side_s1.last <= s_axis_tlast;
			side_s1.en   <= enable_q;
		end
	end

	rafe_coef_mem #(
		.NUM_MATERIALS(NUM_MATERIALS)
	) u_coef_mem (
		.clk    (clk),
		.wr_en  (s_acc && (in_mode == MODE_COEF)),
		.wr_mat (in_mat),
		.wr_sel (in_sel),
		.wr_val (in_coef),
		.rd_en  (adv[1]),
		.rd_mat (in_mat),
		.rd_data(coef_s1)
	);

	rafe_datapath u_datapath (
		.clk    (clk),
		.adv    (adv[NUM_STG:2]),
		.spin_s1(spin_s1),
		.coef_s1(coef_s1),
		.side_s1(side_s1),
		.res    (res)
	);

	assign m_axis_tvalid = v_q[NUM_STG];
	assign m_axis_tdata  = {res.energy, res.fout[2], res.fout[1], res.fout[0]};
	assign m_axis_tlast  = res.last;

endmodule
